[design/csma_pkg.sv]
// Shared constants, register codes and types for the CSMA backoff MAC tick block.
`timescale 1ns / 1ps
`default_nettype none

package csma_pkg;

  localparam int TICK_WIDTH   = 16;
  localparam int ADDR_WIDTH   = 32;
  localparam int HEADER_BYTES = 5;
  localparam int MAX_BACKOFF  = 8;

  localparam int EXP_W   = 4;
  localparam int DRAW_W  = 15;
  localparam int LEN_W   = 8;
  localparam int SLOT_W  = 8;
  localparam int CNT_W   = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam int PROD_W = DRAW_W + SLOT_W;
  localparam int DUE_W  = ((PROD_W > TICK_WIDTH) ? PROD_W : TICK_WIDTH) + 1;

  localparam logic [CFG_IDX_W-1:0] REG_OWN_ADDR   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BCAST_ADDR = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MCAST_ADDR = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BACKOFF_INIT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SLOT_TICKS = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BUSY_THRESH = 3'd5;

  localparam logic [ADDR_WIDTH-1:0] BCAST_RESET = '1;
  localparam logic [SLOT_W-1:0]     SLOT_RESET  = 8'd1;
  localparam logic signed [7:0]     THRESH_RESET = -8'sd56;

  typedef struct packed {
    logic             indication;
    logic [LEN_W-1:0] payload_length;
    logic [LEN_W-1:0] level;
  } rx_result_t;

  typedef struct packed {
    logic             start;
    logic [LEN_W-1:0] frame_length;
    logic [CNT_W-1:0] attempts;
  } tx_result_t;

  typedef struct packed {
    logic             load;
    logic [EXP_W-1:0] value;
  } exp_load_t;

endpackage

`default_nettype wire

[design/csma_rx_filter.sv]
// Receive address filter and payload length for one tick.
`timescale 1ns / 1ps
`default_nettype none

module csma_rx_filter (
  input  wire logic                           frame_valid,
  input  wire logic [csma_pkg::ADDR_WIDTH-1:0] destination,
  input  wire logic [csma_pkg::LEN_W-1:0]     frame_length,
  input  wire logic [csma_pkg::LEN_W-1:0]     signal_level,
  input  wire logic [csma_pkg::ADDR_WIDTH-1:0] own_address,
  input  wire logic [csma_pkg::ADDR_WIDTH-1:0] broadcast_address,
  input  wire logic [csma_pkg::ADDR_WIDTH-1:0] multicast_address,
  output csma_pkg::rx_result_t                result
);
  import csma_pkg::*;

  localparam logic [LEN_W-1:0] HDR = LEN_W'(HEADER_BYTES);

  logic hit;

  assign hit = frame_valid && (destination == own_address ||
                               destination == broadcast_address ||
                               destination == multicast_address);

  always_comb begin
    result.indication     = hit;
    result.payload_length = '0;
    result.level          = '0;
    if (hit) begin
      result.payload_length = (frame_length > HDR) ? (frame_length - HDR) : '0;
      result.level          = signal_level;
    end
  end

endmodule

`default_nettype wire

[design/csma_tx_ctrl.sv]
// Transmit attempt, carrier sense and binary exponential backoff state.
`timescale 1ns / 1ps
`default_nettype none

module csma_tx_ctrl (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         advance,
  input  wire logic                         send_request,
  input  wire logic [csma_pkg::LEN_W-1:0]   send_payload_length,
  input  wire logic                         idle,
  input  wire logic [csma_pkg::DRAW_W-1:0]  random_draw,
  input  wire logic [csma_pkg::SLOT_W-1:0]  slot_ticks,
  input  wire csma_pkg::exp_load_t          exp_load,
  output csma_pkg::tx_result_t              result
);
  import csma_pkg::*;

  localparam logic [EXP_W:0] EXP_MAX = (EXP_W+1)'(MAX_BACKOFF);

  logic [TICK_WIDTH-1:0] tick_count, tick_count_next;
  logic [EXP_W-1:0]      backoff_exponent, backoff_exponent_next;
  logic [TICK_WIDTH-1:0] backoff_due_tick, backoff_due_tick_next;
  logic                  backoff_armed, backoff_armed_next;
  logic                  listening, listening_next;
  logic [CNT_W-1:0]      attempts, attempts_next;
  logic [LEN_W-1:0]      pending_frame_length, pending_frame_length_next;

  logic [LEN_W:0]        req_len;
  logic                  armed_a, listen_a, fire, attempt;
  logic [EXP_W:0]        exp_inc;
  logic [DRAW_W-1:0]     slots;
  logic [PROD_W-1:0]     product;
  logic [DUE_W-1:0]      due_sum;

  // A pending attempt is always consumed within the tick that raises it,
  // so it needs no register: it is the request or the timer firing.
  always_comb begin
    req_len  = {1'b0, send_payload_length} + (LEN_W+1)'(HEADER_BYTES);
    armed_a  = send_request ? 1'b0 : backoff_armed;
    listen_a = send_request ? 1'b0 : listening;
    attempts_next = send_request ? '0 : attempts;
    pending_frame_length_next = pending_frame_length;
    if (send_request) begin
      pending_frame_length_next = req_len[LEN_W] ? '1 : req_len[LEN_W-1:0];
    end

    fire    = armed_a && (backoff_due_tick == tick_count);
    attempt = send_request || fire;
    backoff_armed_next    = fire ? 1'b0 : armed_a;
    backoff_exponent_next = backoff_exponent;
    listening_next        = listen_a;
    exp_inc = {1'b0, backoff_exponent} + (EXP_W+1)'(1);

    result.start        = 1'b0;
    result.frame_length = '0;
    if (attempt) begin
      attempts_next = attempts_next + CNT_W'(1);
      if (idle) begin
        listening_next      = 1'b0;
        result.start        = 1'b1;
        result.frame_length = pending_frame_length_next;
      end else begin
        backoff_exponent_next = (exp_inc > EXP_MAX) ? EXP_MAX[EXP_W-1:0]
                                                    : exp_inc[EXP_W-1:0];
        listening_next = 1'b1;
      end
    end

    slots   = random_draw >> (EXP_W'(DRAW_W) - backoff_exponent_next);
    product = PROD_W'(slots) * PROD_W'(slot_ticks);
    due_sum = DUE_W'(product) + DUE_W'(tick_count) + DUE_W'(1);
    backoff_due_tick_next = backoff_due_tick;
    if (!result.start && listening_next && idle) begin
      listening_next        = 1'b0;
      backoff_due_tick_next = due_sum[TICK_WIDTH-1:0];
      backoff_armed_next    = 1'b1;
    end

    tick_count_next = tick_count + TICK_WIDTH'(1);
    result.attempts = attempts_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count           <= '0;
      backoff_exponent     <= '0;
      backoff_due_tick     <= '0;
      backoff_armed        <= 1'b0;
      listening            <= 1'b0;
      attempts             <= '0;
      pending_frame_length <= '0;
    end else if (exp_load.load) begin
      backoff_exponent <= exp_load.value;
    end else if (advance) begin
      tick_count           <= tick_count_next;
      backoff_exponent     <= backoff_exponent_next;
      backoff_due_tick     <= backoff_due_tick_next;
      backoff_armed        <= backoff_armed_next;
      listening            <= listening_next;
      attempts             <= attempts_next;
      pending_frame_length <= pending_frame_length_next;
    end
  end

endmodule

`default_nettype wire

[design/csma_backoff_mac_tick.sv]
// Top level of the CSMA backoff MAC tick block: config, input and result registers.
//
//   port group   direction  handshake            payload
//   in_*         sink       in_valid/in_stall    one tick request
//   out_*        source     out_valid/out_stall  one result per tick
//   cfg_*        sink       cfg_valid/cfg_ready  cfg_index, cfg_data
//
// Each request is latched in the input register, processed combinationally against
// the MAC state and written to the result register; one request per cycle while
// out_stall is low. A stalled result holds the input register and stalls the input
// side only when both are full. Reset (rst, synchronous) loads the register reset
// values and clears control state, not data registers; cfg_ready is always high.
`timescale 1ns / 1ps
`default_nettype none

module csma_backoff_mac_tick (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic                              send_request,
  input  wire logic [csma_pkg::LEN_W-1:0]        send_payload_length,
  input  wire logic signed [7:0]                 channel_rssi,
  input  wire logic [csma_pkg::DRAW_W-1:0]       random_draw,
  input  wire logic                              rx_frame_valid,
  input  wire logic [csma_pkg::ADDR_WIDTH-1:0]   rx_destination,
  input  wire logic [csma_pkg::LEN_W-1:0]        rx_frame_length,
  input  wire logic [csma_pkg::LEN_W-1:0]        rx_signal_level,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic                                   rx_indication,
  output logic [csma_pkg::LEN_W-1:0]             rx_payload_length,
  output logic [csma_pkg::LEN_W-1:0]             rx_level_out,
  output logic                                   tx_start,
  output logic [csma_pkg::LEN_W-1:0]             tx_frame_length,
  output logic [csma_pkg::CNT_W-1:0]             attempt_count,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [csma_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [csma_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import csma_pkg::*;

  // configuration registers
  logic [ADDR_WIDTH-1:0] own_address, broadcast_address, multicast_address;
  logic [SLOT_W-1:0]     slot_ticks;
  logic signed [7:0]     busy_threshold;
  logic                  cfg_write;
  exp_load_t             exp_load;

  // input register
  logic                  in_full;
  logic                  q_send_request;
  logic [LEN_W-1:0]      q_send_payload_length;
  logic signed [7:0]     q_channel_rssi;
  logic [DRAW_W-1:0]     q_random_draw;
  logic                  q_rx_frame_valid;
  logic [ADDR_WIDTH-1:0] q_rx_destination;
  logic [LEN_W-1:0]      q_rx_frame_length;
  logic [LEN_W-1:0]      q_rx_signal_level;

  logic       advance, in_take, idle;
  rx_result_t rx_res;
  tx_result_t tx_res;

  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      own_address       <= '0;
      broadcast_address <= BCAST_RESET;
      multicast_address <= '0;
      slot_ticks        <= SLOT_RESET;
      busy_threshold    <= THRESH_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_OWN_ADDR:    own_address       <= cfg_data[ADDR_WIDTH-1:0];
        REG_BCAST_ADDR:  broadcast_address <= cfg_data[ADDR_WIDTH-1:0];
        REG_MCAST_ADDR:  multicast_address <= cfg_data[ADDR_WIDTH-1:0];
        REG_SLOT_TICKS:  slot_ticks        <= cfg_data[SLOT_W-1:0];
        REG_BUSY_THRESH: busy_threshold    <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // the initial exponent only matters at the moment it is written
  assign exp_load.load  = cfg_write && (cfg_index == REG_BACKOFF_INIT);
  assign exp_load.value = cfg_data[EXP_W-1:0];

  assign advance  = in_full && (!out_valid || !out_stall);
  assign in_stall = in_full && !advance;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_take) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      q_send_request        <= send_request;
      q_send_payload_length <= send_payload_length;
      q_channel_rssi        <= channel_rssi;
      q_random_draw         <= random_draw;
      q_rx_frame_valid      <= rx_frame_valid;
      q_rx_destination      <= rx_destination;
      q_rx_frame_length     <= rx_frame_length;
      q_rx_signal_level     <= rx_signal_level;
    end
  end

  assign idle = q_channel_rssi < busy_threshold;

  csma_rx_filter u_rx_filter (
    .frame_valid       (q_rx_frame_valid),
    .destination       (q_rx_destination),
    .frame_length      (q_rx_frame_length),
    .signal_level      (q_rx_signal_level),
    .own_address       (own_address),
    .broadcast_address (broadcast_address),
    .multicast_address (multicast_address),
    .result            (rx_res)
  );

  csma_tx_ctrl u_tx_ctrl (
    .clk                 (clk),
    .rst                 (rst),
    .advance             (advance),
    .send_request        (q_send_request),
    .send_payload_length (q_send_payload_length),
    .idle                (idle),
    .random_draw         (q_random_draw),
    .slot_ticks          (slot_ticks),
    .exp_load            (exp_load),
    .result              (tx_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rx_indication     <= rx_res.indication;
      rx_payload_length <= rx_res.payload_length;
      rx_level_out      <= rx_res.level;
      tx_start          <= tx_res.start;
      tx_frame_length   <= tx_res.frame_length;
      attempt_count     <= tx_res.attempts;
    end
  end

endmodule

`default_nettype wire
